>>> src/polynomial_point_to_point_trajectory_defines.svh
// Assertion macros shared by the trajectory checker.
// Needs nothing else; include by bare file name.
`ifndef POLYNOMIAL_POINT_TO_POINT_TRAJECTORY_DEFINES_SVH
`define POLYNOMIAL_POINT_TO_POINT_TRAJECTORY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define PPT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define PPT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ppt_pkg.sv
// Shared types and constants for the point-to-point trajectory evaluator.
// Used by polynomial_point_to_point_trajectory and ppt_checker; depends on nothing.
package ppt_pkg;

    // Port and field widths
    localparam int PHASE_W    = 18;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W     = 2;
    localparam int RP_W       = 24;
    localparam int PT_W       = 32;
    localparam int DIFF_W     = PT_W + 1;
    localparam int FRAC_OUT   = 16;

    // Register stages from input transfer to output register
    localparam int PIPE_DEPTH = 8;
    localparam int OCC_W      = 4;

    // Scaling mode codes
    localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUINTIC = 2'd1;

    // Reset values
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_QUINTIC;
    localparam logic [RP_W-1:0]   RP_RESET   = 24'd65536;

    // Saturation bounds of a result field
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Polynomial coefficients
    localparam int C2  = 2;
    localparam int C3  = 3;
    localparam int C6  = 6;
    localparam int C10 = 10;
    localparam int C15 = 15;
    localparam int C30 = 30;
    localparam int C60 = 60;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALING_MODE = 4'd0,
        REG_RECIP_PERIOD = 4'd1,
        REG_START_X      = 4'd2,
        REG_START_Y      = 4'd3,
        REG_START_Z      = 4'd4,
        REG_END_X        = 4'd5,
        REG_END_Y        = 4'd6,
        REG_END_Z        = 4'd7
    } cfg_reg_t;

endpackage

>>> src/polynomial_point_to_point_trajectory.sv
// Top level of the three-axis point-to-point trajectory evaluator.
// Depends on ppt_pkg (scoped names).

// One phase sample per transfer, one result per sample. The block takes a new sample every
// clock cycle while the output side is ready or some stage is empty. The depth is set by the
// range check and the chain of multipliers (square, cube, time scaling, period scaling,
// per-axis products, partial-product sum, rounding and saturation), one register stage
// each. Backpressure from m_ready stalls only the stages that hold data; bubbles fill.
// Configuration writes take effect through the configuration registers and must be made while no sample is in
// flight; cfg_ready is always high and writes to an index beyond the map are dropped.
module polynomial_point_to_point_trajectory #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Phase input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ppt_pkg::PHASE_W-1:0]     s_phase,
    // Result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_pos_x,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_pos_y,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_pos_z,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_vel_x,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_vel_y,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_vel_z,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_acc_x,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_acc_y,
    output logic signed [ppt_pkg::OUT_W-1:0]       m_acc_z,
    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int F        = PHASE_FRAC_BITS;
    localparam int D        = ppt_pkg::PIPE_DEPTH;
    localparam int OUT_W    = ppt_pkg::OUT_W;
    localparam int RP_W     = ppt_pkg::RP_W;
    localparam int PT_W     = ppt_pkg::PT_W;
    localparam int DIFF_W   = ppt_pkg::DIFF_W;
    localparam int FRAC_OUT = ppt_pkg::FRAC_OUT;

    // Internal widths
    localparam int CW    = (F + 2 > ppt_pkg::PHASE_W) ? F + 2 : ppt_pkg::PHASE_W;
    localparam int UW    = F + 1;             // unsigned values in [0, one]
    localparam int WW    = F + 2;             // signed u - s
    localparam int PYW   = F + 6;             // quintic inner polynomial
    localparam int HW    = F + 6;             // h
    localparam int DHW   = F + 3;             // h'
    localparam int DDW   = F + 6;             // h''
    localparam int MDPW  = UW + 1 + WW;
    localparam int HQPW  = UW + 1 + PYW;
    localparam int KVW   = DHW + RP_W - F;
    localparam int R2W   = 2 * RP_W - FRAC_OUT;
    localparam int PKW   = DDW + R2W + 1;
    localparam int KAW   = PKW - F;
    localparam int KALW  = 20;
    localparam int HPW   = HW + DIFF_W;
    localparam int HDW   = HPW - F;
    localparam int VPW   = KVW + 1 + DIFF_W;
    localparam int PLW   = DIFF_W + KALW + 1;
    localparam int PHW   = DIFF_W + KAW - KALW;
    localparam int ACW   = DIFF_W + KAW;
    localparam int RW    = ACW - FRAC_OUT;

    localparam logic signed [CW-1:0] ONE_CMP = CW'(1) << F;
    localparam logic [UW-1:0]        ONE_U   = UW'(1) << F;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ppt_pkg::MODE_W-1:0]  mode_reg;
    logic [RP_W-1:0]             rp_reg;
    logic signed [PT_W-1:0]      start_reg [3];
    logic signed [PT_W-1:0]      end_reg [3];
    logic signed [DIFF_W-1:0]    diff_reg [3];
    logic [R2W-1:0]              r2_reg;
    logic [2*RP_W-1:0]           rp_sq;
    logic [2*RP_W-1:0]           rp_sq_rnd;
    logic [R2W-1:0]              r2_next;

    assign cfg_ready = 1'b1;

    // Take register writes; drop indexes beyond the map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ppt_pkg::MODE_RESET;
            rp_reg   <= ppt_pkg::RP_RESET;
            for (int i = 0; i < 3; i++) begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (ppt_pkg::cfg_reg_t'(cfg_index))
                ppt_pkg::REG_SCALING_MODE: mode_reg     <= cfg_data[ppt_pkg::MODE_W-1:0];
                ppt_pkg::REG_RECIP_PERIOD: rp_reg       <= cfg_data[RP_W-1:0];
                ppt_pkg::REG_START_X:      start_reg[0] <= $signed(cfg_data[PT_W-1:0]);
                ppt_pkg::REG_START_Y:      start_reg[1] <= $signed(cfg_data[PT_W-1:0]);
                ppt_pkg::REG_START_Z:      start_reg[2] <= $signed(cfg_data[PT_W-1:0]);
                ppt_pkg::REG_END_X:        end_reg[0]   <= $signed(cfg_data[PT_W-1:0]);
                ppt_pkg::REG_END_Y:        end_reg[1]   <= $signed(cfg_data[PT_W-1:0]);
                ppt_pkg::REG_END_Z:        end_reg[2]   <= $signed(cfg_data[PT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Derive the axis spans and the squared reciprocal period from configuration
    assign rp_sq     = rp_reg * rp_reg;
    assign rp_sq_rnd = rp_sq + ((2 * RP_W)'(1) << (FRAC_OUT - 1));
    assign r2_next   = rp_sq_rnd[FRAC_OUT +: R2W];

    always_ff @(posedge aclk) begin
        r2_reg <= r2_next;
        for (int i = 0; i < 3; i++) begin
            diff_reg[i] <= DIFF_W'(end_reg[i]) - DIFF_W'(start_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and advance chain
    // ------------------------------------------------------------------
    logic [D-1:0] vld_reg;
    logic [D-1:0] vld_next;
    logic [D-1:0] adv;

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        adv[D-1] = !vld_reg[D-1] || m_ready;
        for (int k = D - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < D; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[D-1];

    // ------------------------------------------------------------------
    // Stage 1: range check, s and u = one - s
    // ------------------------------------------------------------------
    logic signed [CW-1:0] phase_ext;
    logic                 mode_ok;
    logic                 in_range;
    logic [UW-1:0]        s_next;
    logic [UW-1:0]        u_next;
    logic signed [WW-1:0] w_next;

    assign phase_ext = CW'(s_phase);
    assign mode_ok   = (mode_reg == ppt_pkg::MODE_CUBIC) || (mode_reg == ppt_pkg::MODE_QUINTIC);
    assign in_range  = !phase_ext[CW-1] && (phase_ext <= ONE_CMP) && mode_ok;
    assign s_next    = in_range ? UW'(phase_ext) : '0;
    assign u_next    = ONE_U - s_next;
    assign w_next    = $signed({1'b0, u_next}) - $signed({1'b0, s_next});

    logic [UW-1:0]        st1_s_reg;
    logic [UW-1:0]        st1_u_reg;
    logic signed [WW-1:0] st1_w_reg;
    logic                 st1_zero_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_s_reg    <= s_next;
            st1_u_reg    <= u_next;
            st1_w_reg    <= w_next;
            st1_zero_reg <= !in_range;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: s^2 and m = s*u
    // ------------------------------------------------------------------
    logic [2*UW-1:0] sq_prod;
    logic [2*UW-1:0] sq_rnd;
    logic [2*UW-1:0] su_prod;
    logic [2*UW-1:0] su_rnd;

    assign sq_prod = st1_s_reg * st1_s_reg;
    assign sq_rnd  = sq_prod + ((2 * UW)'(1) << (F - 1));
    assign su_prod = st1_s_reg * st1_u_reg;
    assign su_rnd  = su_prod + ((2 * UW)'(1) << (F - 1));

    logic [UW-1:0]        st2_sq_reg;
    logic [UW-1:0]        st2_m_reg;
    logic [UW-1:0]        st2_s_reg;
    logic signed [WW-1:0] st2_w_reg;
    logic                 st2_zero_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            st2_sq_reg   <= sq_rnd[F +: UW];
            st2_m_reg    <= su_rnd[F +: UW];
            st2_s_reg    <= st1_s_reg;
            st2_w_reg    <= st1_w_reg;
            st2_zero_reg <= st1_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: s^3, m^2, m*(u - s) and the quintic inner polynomial
    // ------------------------------------------------------------------
    logic [2*UW-1:0]        cube_prod;
    logic [2*UW-1:0]        cube_rnd;
    logic [2*UW-1:0]        mm_prod;
    logic [2*UW-1:0]        mm_rnd;
    logic signed [MDPW-1:0] md_prod;
    logic [MDPW-1:0]        md_rnd;
    logic signed [PYW-1:0]  poly_next;

    assign cube_prod = st2_sq_reg * st2_s_reg;
    assign cube_rnd  = cube_prod + ((2 * UW)'(1) << (F - 1));
    assign mm_prod   = st2_m_reg * st2_m_reg;
    assign mm_rnd    = mm_prod + ((2 * UW)'(1) << (F - 1));
    assign md_prod   = $signed({1'b0, st2_m_reg}) * st2_w_reg;
    // Round to nearest, ties away from zero
    assign md_rnd    = md_prod + (MDPW'(1) << (F - 1)) - MDPW'(md_prod[MDPW-1]);
    assign poly_next = PYW'(ppt_pkg::C10 * (1 << F) - ppt_pkg::C15 * int'(st2_s_reg)
                            + ppt_pkg::C6 * int'(st2_sq_reg));

    logic [UW-1:0]         st3_cube_reg;
    logic [UW-1:0]         st3_mm_reg;
    logic signed [WW-1:0]  st3_md_reg;
    logic signed [PYW-1:0] st3_poly_reg;
    logic [UW-1:0]         st3_sq_reg;
    logic [UW-1:0]         st3_m_reg;
    logic signed [WW-1:0]  st3_w_reg;
    logic                  st3_zero_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            st3_cube_reg <= cube_rnd[F +: UW];
            st3_mm_reg   <= mm_rnd[F +: UW];
            st3_md_reg   <= $signed(md_rnd[F +: WW]);
            st3_poly_reg <= poly_next;
            st3_sq_reg   <= st2_sq_reg;
            st3_m_reg    <= st2_m_reg;
            st3_w_reg    <= st2_w_reg;
            st3_zero_reg <= st2_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: time scaling h and its derivatives, by mode
    // ------------------------------------------------------------------
    logic signed [HQPW-1:0] hq_prod;
    logic [HQPW-1:0]        hq_rnd;
    logic signed [HW-1:0]   h_q;
    logic signed [HW-1:0]   h_c;
    logic [DHW-1:0]         dh_q;
    logic [DHW-1:0]         dh_c;
    logic signed [DDW-1:0]  ddh_q;
    logic signed [DDW-1:0]  ddh_c;
    logic                   quintic;
    logic signed [HW-1:0]   h_next;
    logic [DHW-1:0]         dh_next;
    logic signed [DDW-1:0]  ddh_next;

    assign hq_prod = $signed({1'b0, st3_cube_reg}) * st3_poly_reg;
    assign hq_rnd  = hq_prod + (HQPW'(1) << (F - 1)) - HQPW'(hq_prod[HQPW-1]);
    assign h_q     = $signed(hq_rnd[F +: HW]);
    assign h_c     = HW'(ppt_pkg::C3 * int'(st3_sq_reg) - ppt_pkg::C2 * int'(st3_cube_reg));
    assign dh_q    = DHW'(ppt_pkg::C30 * int'(st3_mm_reg));
    assign dh_c    = DHW'(ppt_pkg::C6 * int'(st3_m_reg));
    assign ddh_q   = DDW'(ppt_pkg::C60 * int'(st3_md_reg));
    assign ddh_c   = DDW'(ppt_pkg::C6 * int'(st3_w_reg));
    assign quintic = (mode_reg == ppt_pkg::MODE_QUINTIC);

    // Force zero scaling for an out-of-range phase or an unsupported mode
    always_comb begin
        if (st3_zero_reg) begin
            h_next   = '0;
            dh_next  = '0;
            ddh_next = '0;
        end else if (quintic) begin
            h_next   = h_q;
            dh_next  = dh_q;
            ddh_next = ddh_q;
        end else begin
            h_next   = h_c;
            dh_next  = dh_c;
            ddh_next = ddh_c;
        end
    end

    logic signed [HW-1:0]  st4_h_reg;
    logic [DHW-1:0]        st4_dh_reg;
    logic signed [DDW-1:0] st4_ddh_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            st4_h_reg   <= h_next;
            st4_dh_reg  <= dh_next;
            st4_ddh_reg <= ddh_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: period scaling and per-axis position offset
    // ------------------------------------------------------------------
    logic [DHW+RP_W-1:0]   kv_prod;
    logic [DHW+RP_W-1:0]   kv_rnd;
    logic signed [PKW-1:0] ka_prod;
    logic [PKW-1:0]        ka_rnd;
    logic signed [HPW-1:0] hd_prod [3];
    logic [HPW-1:0]        hd_rnd [3];

    assign kv_prod = st4_dh_reg * rp_reg;
    assign kv_rnd  = kv_prod + ((DHW + RP_W)'(1) << (F - 1));
    assign ka_prod = st4_ddh_reg * $signed({1'b0, r2_reg});
    assign ka_rnd  = ka_prod + (PKW'(1) << (F - 1)) - PKW'(ka_prod[PKW-1]);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            hd_prod[a] = st4_h_reg * diff_reg[a];
            hd_rnd[a]  = hd_prod[a] + (HPW'(1) << (F - 1)) - HPW'(hd_prod[a][HPW-1]);
        end
    end

    logic [KVW-1:0]        st5_kv_reg;
    logic signed [KAW-1:0] st5_ka_reg;
    logic signed [HDW-1:0] st5_hd_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            st5_kv_reg <= kv_rnd[F +: KVW];
            st5_ka_reg <= $signed(ka_rnd[F +: KAW]);
            for (int a = 0; a < 3; a++) begin
                st5_hd_reg[a] <= $signed(hd_rnd[a][F +: HDW]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: position, velocity, acceleration partial products
    // ------------------------------------------------------------------
    logic signed [VPW-1:0] vel_prod [3];
    logic [VPW-1:0]        vel_rnd [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            vel_prod[a] = $signed({1'b0, st5_kv_reg}) * diff_reg[a];
            vel_rnd[a]  = vel_prod[a] + (VPW'(1) << (FRAC_OUT - 1))
                          - VPW'(vel_prod[a][VPW-1]);
        end
    end

    logic signed [OUT_W-1:0] st6_pos_reg [3];
    logic signed [OUT_W-1:0] st6_vel_reg [3];
    logic signed [PLW-1:0]   st6_plo_reg [3];
    logic signed [PHW-1:0]   st6_phi_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            for (int a = 0; a < 3; a++) begin
                st6_pos_reg[a] <= OUT_W'(start_reg[a]) + OUT_W'(st5_hd_reg[a]);
                st6_vel_reg[a] <= OUT_W'($signed(vel_rnd[a][VPW-1:FRAC_OUT]));
                st6_plo_reg[a] <= diff_reg[a] * $signed({1'b0, st5_ka_reg[KALW-1:0]});
                st6_phi_reg[a] <= diff_reg[a] * $signed(st5_ka_reg[KAW-1:KALW]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: sum the acceleration partial products
    // ------------------------------------------------------------------
    logic signed [ACW-1:0]   st7_acc_reg [3];
    logic signed [OUT_W-1:0] st7_pos_reg [3];
    logic signed [OUT_W-1:0] st7_vel_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            for (int a = 0; a < 3; a++) begin
                st7_acc_reg[a] <= (ACW'(st6_phi_reg[a]) << KALW) + ACW'(st6_plo_reg[a]);
                st7_pos_reg[a] <= st6_pos_reg[a];
                st7_vel_reg[a] <= st6_vel_reg[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: round and saturate acceleration, output register
    // ------------------------------------------------------------------
    logic [ACW-1:0]   acc_t [3];
    logic [RW-1:0]    acc_r [3];
    logic [OUT_W-1:0] acc_next [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc_t[a] = st7_acc_reg[a] + (ACW'(1) << (FRAC_OUT - 1))
                       - ACW'(st7_acc_reg[a][ACW-1]);
            acc_r[a] = acc_t[a][ACW-1:FRAC_OUT];
            if (acc_r[a][RW-1:OUT_W-1] != {(RW - OUT_W + 1){acc_r[a][RW-1]}}) begin
                acc_next[a] = acc_r[a][RW-1] ? ppt_pkg::OUT_MIN : ppt_pkg::OUT_MAX;
            end else begin
                acc_next[a] = acc_r[a][OUT_W-1:0];
            end
        end
    end

    logic signed [OUT_W-1:0] out_pos_reg [3];
    logic signed [OUT_W-1:0] out_vel_reg [3];
    logic signed [OUT_W-1:0] out_acc_reg [3];

    always_ff @(posedge aclk) begin
        if (adv[D-1]) begin
            for (int a = 0; a < 3; a++) begin
                out_pos_reg[a] <= st7_pos_reg[a];
                out_vel_reg[a] <= st7_vel_reg[a];
                out_acc_reg[a] <= $signed(acc_next[a]);
            end
        end
    end

    assign m_pos_x = out_pos_reg[0];
    assign m_pos_y = out_pos_reg[1];
    assign m_pos_z = out_pos_reg[2];
    assign m_vel_x = out_vel_reg[0];
    assign m_vel_y = out_vel_reg[1];
    assign m_vel_z = out_vel_reg[2];
    assign m_acc_x = out_acc_reg[0];
    assign m_acc_y = out_acc_reg[1];
    assign m_acc_z = out_acc_reg[2];

endmodule

>>> src/ppt_checker.sv
// Port-level checker for the trajectory evaluator, bound to the top level.
// Depends on ppt_pkg and polynomial_point_to_point_trajectory_defines.svh.
`include "polynomial_point_to_point_trajectory_defines.svh"

module ppt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [ppt_pkg::OUT_W-1:0]    m_pos_x,
    input logic signed [ppt_pkg::OUT_W-1:0]    m_acc_z
);

    logic [ppt_pkg::OCC_W-1:0] occ_reg;
    logic [ppt_pkg::OCC_W-1:0] occ_next;

    // Track samples accepted but not yet delivered
    always_comb begin
        occ_next = occ_reg;
        if (s_valid && s_ready) begin
            occ_next = occ_next + 1'b1;
        end
        if (m_valid && m_ready) begin
            occ_next = occ_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Hold a stalled result
    `PPT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pos_x) && $stable(m_acc_z), "stalled result changed")

    // A ready sink lets the pipe take a new sample
    `PPT_ASSERT_IMP(a_ready_when_drained, aclk, aresetn, m_ready, s_ready, "input stalled while output drains")

    // Never present a result without a sample in flight
    `PPT_ASSERT_IMP(a_no_phantom, aclk, aresetn, m_valid, occ_reg != '0, "result without accepted sample")

    // Never hold more samples than there are stages
    `PPT_ASSERT_IMP(a_depth_bound, aclk, aresetn, s_valid && s_ready && !m_ready, occ_reg < ppt_pkg::OCC_W'(ppt_pkg::PIPE_DEPTH), "sample accepted into a full pipe")

endmodule

bind polynomial_point_to_point_trajectory ppt_checker u_ppt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_pos_x (m_pos_x),
    .m_acc_z (m_acc_z)
);
